@@ sv/ost_pkg.sv @@
package ost_pkg;

  localparam int GRID_SIZE_DEF = 256;
  localparam int ROT_STEPS     = 30;

  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  localparam logic [31:0] TIME_RST    = 32'd0;
  localparam logic [15:0] KSTEP_RST   = 16'd4118;
  localparam logic [19:0] GRAVITY_RST = 20'd642908;

  localparam logic [1:0] REG_TIME    = 2'd0;
  localparam logic [1:0] REG_KSTEP   = 2'd1;
  localparam logic [1:0] REG_GRAVITY = 2'd2;

  typedef logic signed [34:0] ang_t;
  typedef logic signed [33:0] cs_t;

  typedef struct packed {
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic signed [23:0] p;
    logic signed [23:0] q;
  } amp_t;

  function automatic ang_t atan_q30(input int i);
    unique case (i)
      0: atan_q30 = 35'sd843314857;
      1: atan_q30 = 35'sd497837829;
      2: atan_q30 = 35'sd263043837;
      3: atan_q30 = 35'sd133525159;
      4: atan_q30 = 35'sd67021687;
      5: atan_q30 = 35'sd33543516;
      6: atan_q30 = 35'sd16775851;
      7: atan_q30 = 35'sd8388437;
      8: atan_q30 = 35'sd4194283;
      9: atan_q30 = 35'sd2097149;
      default: atan_q30 = (i < 30) ? ang_t'(64'sd1 <<< (30 - i)) : '0;
    endcase
  endfunction

endpackage

@@ sv/ost_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module ost_sqrt import ost_pkg::*; #(
  parameter int IW = 36,
  parameter int SW = 32
) (
  input  logic            clk,
  input  logic [IW-1:0]   in_val,
  input  logic [SW-1:0]   in_side,
  output logic [IW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);
  localparam int NS = IW / 2;

  logic [IW-1:0] rem_r  [NS+1];
  logic [NS-1:0] root_r [NS+1];
  logic [SW-1:0] side_r [NS+1];

  always_comb begin
    rem_r[0]  = in_val;
    root_r[0] = '0;
    side_r[0] = in_side;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam int B = NS - 1 - s;
    logic [IW+1:0] trial;
    logic [IW+1:0] rem_ext;
    always_comb begin
      trial   = ((IW+2)'(root_r[s]) << (B + 1)) | ((IW+2)'(1) << (2 * B));
      rem_ext = (IW+2)'(rem_r[s]);
    end
    always_ff @(posedge clk) begin
      side_r[s+1] <= side_r[s];
      if (rem_ext >= trial) begin
        rem_r[s+1]  <= IW'(rem_ext - trial);
        root_r[s+1] <= root_r[s] | (NS'(1) << B);
      end else begin
        rem_r[s+1]  <= rem_r[s];
        root_r[s+1] <= root_r[s];
      end
    end
  end

  assign out_root = root_r[NS];
  assign out_side = side_r[NS];
endmodule

@@ sv/ost_cordic.sv @@
// Rotation CORDIC, one micro-rotation per stage.
module ost_cordic import ost_pkg::*; #(
  parameter int SW = 8
) (
  input  logic          clk,
  input  ang_t          in_ang,
  input  logic          in_flip,
  input  logic [SW-1:0] in_side,
  output cs_t           out_cos,
  output cs_t           out_sin,
  output logic [SW-1:0] out_side
);
  cs_t           x_r [ROT_STEPS+1];
  cs_t           y_r [ROT_STEPS+1];
  ang_t          a_r [ROT_STEPS+1];
  logic          f_r [ROT_STEPS+1];
  logic [SW-1:0] s_r [ROT_STEPS+1];

  always_comb begin
    x_r[0] = GAIN_Q30;
    y_r[0] = '0;
    a_r[0] = in_ang;
    f_r[0] = in_flip;
    s_r[0] = in_side;
  end

  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      f_r[i+1] <= f_r[i];
      s_r[i+1] <= s_r[i];
      if (!a_r[i][34]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - atan_q30(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + atan_q30(i);
      end
    end
  end

  assign out_cos  = f_r[ROT_STEPS] ? -x_r[ROT_STEPS] : x_r[ROT_STEPS];
  assign out_sin  = f_r[ROT_STEPS] ? -y_r[ROT_STEPS] : y_r[ROT_STEPS];
  assign out_side = s_r[ROT_STEPS];
endmodule

@@ sv/ocean_spectrum_time_update.sv @@
// Ocean spectrum time update: one frequency bin per cycle.
// Input: pulse start with row/column index and h0, conj(h0(-k)) amplitudes.
// busy stays low, so a bin may be issued every cycle.
// Output: out_valid strobes for one cycle with height_re/height_im/saturated.
// Results come out in issue order through the registered pipeline: k, the
// |k| root, the omega product, the omega root, the phase product, the 2*pi
// reduction, 30 CORDIC stages, then the complex products and rounding.
// Configuration: cfg_valid/cfg_ready (always ready) writes cfg_index/cfg_data;
// index 0 time_now, 1 k_step, 2 gravity, others are ignored. Write only while
// no bin is in flight. Reset (rst_n low, synchronous) clears the valid
// pipeline and restores register defaults. The receiver cannot stall; each
// result is a single-cycle transfer.
module ocean_spectrum_time_update import ost_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_row_index,
  input  logic [7:0]         in_col_index,
  input  logic signed [23:0] in_h0_re,
  input  logic signed [23:0] in_h0_im,
  input  logic signed [23:0] in_h0c_re,
  input  logic signed [23:0] in_h0c_im,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic signed [23:0] out_height_re,
  output logic signed [23:0] out_height_im,
  output logic               out_saturated
);
  localparam int LAT = 91;
  localparam int AW  = $bits(amp_t);

  logic [31:0] time_r;
  logic [15:0] kstep_r;
  logic [19:0] grav_r;
  logic [LAT-1:0] vld_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= TIME_RST;
      kstep_r <= KSTEP_RST;
      grav_r  <= GRAVITY_RST;
      vld_r   <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TIME:    time_r  <= cfg_data;
          REG_KSTEP:   kstep_r <= cfg_data[15:0];
          REG_GRAVITY: grav_r  <= cfg_data[19:0];
          default: ;
        endcase
      end
    end
  end
  assign out_valid = vld_r[LAT-1];

  // stage 1: offsets and k
  amp_t amp_in, amp1_r, amp2_r;
  logic signed [11:0] dm, dn;
  logic signed [28:0] kx_r, ky_r;
  logic [57:0] kx2_r, ky2_r;
  assign amp_in = '{a: in_h0_re, b: in_h0_im, p: in_h0c_re, q: in_h0c_im};
  assign dm = $signed({4'd0, in_row_index}) - 12'(GRID_SIZE / 2);
  assign dn = $signed({4'd0, in_col_index}) - 12'(GRID_SIZE / 2);

  always_ff @(posedge clk) begin
    kx_r   <= 29'(dn) * 29'($signed({1'b0, kstep_r}));
    ky_r   <= 29'(dm) * 29'($signed({1'b0, kstep_r}));
    amp1_r <= amp_in;
    kx2_r  <= 58'(kx_r) * 58'(kx_r);
    ky2_r  <= 58'(ky_r) * 58'(ky_r);
    amp2_r <= amp1_r;
  end

  logic [51:0] ksum;
  logic [25:0] kmag;
  amp_t amp3;
  assign ksum = 52'(kx2_r) + 52'(ky2_r);

  ost_sqrt #(.IW(52), .SW(AW)) u_kmag (
    .clk(clk), .in_val(ksum), .in_side(amp2_r),
    .out_root(kmag), .out_side(amp3)
  );

  logic [45:0] gk_r;
  amp_t amp4_r;
  always_ff @(posedge clk) begin
    gk_r   <= 46'(grav_r) * 46'(kmag);
    amp4_r <= amp3;
  end

  logic [22:0] omega;
  amp_t amp5;
  ost_sqrt #(.IW(46), .SW(AW)) u_omega (
    .clk(clk), .in_val(gk_r), .in_side(amp4_r),
    .out_root(omega), .out_side(amp5)
  );

  // phase = omega * time, split in two partial products
  logic [38:0] pl_r;
  logic [38:0] ph_r;
  logic [55:0] ph_full_r;
  amp_t amp6_r, amp7_r;
  always_ff @(posedge clk) begin
    pl_r      <= 39'(omega) * 39'(time_r[15:0]);
    ph_r      <= 39'(omega) * 39'(time_r[31:16]);
    amp6_r    <= amp5;
    ph_full_r <= (56'(ph_r) << 16) + 56'(pl_r);
    amp7_r    <= amp6_r;
  end

  // reduction mod 2*pi: quotient by reciprocal, then up to two corrections
  localparam logic [33:0] RECIP = 34'((68'd1 << 67) / 68'(TWO_PI_Q32));
  logic [55:0] ph8_r;
  amp_t amp8_r, amp9_r, amp10_r;
  logic [47:0] prod_hi_r;
  always_ff @(posedge clk) begin
    prod_hi_r <= 48'((64'(ph_full_r[55:25]) * 64'(RECIP)) >> 17);
    ph8_r     <= ph_full_r;
    amp8_r    <= amp7_r;
  end
  logic [55:0] ph9_r;
  logic [21:0] q9_r;
  always_ff @(posedge clk) begin
    q9_r    <= 22'(prod_hi_r >> 25);
    ph9_r   <= ph8_r;
    amp9_r  <= amp8_r;
  end
  logic [55:0] rem_r;
  always_ff @(posedge clk) begin
    rem_r   <= ph9_r - 56'(q9_r) * 56'(TWO_PI_Q32);
    amp10_r <= amp9_r;
  end

  logic [55:0] r1, r2;
  ang_t a0, a1;
  logic flip;
  always_comb begin
    r1 = (rem_r >= 56'(TWO_PI_Q32)) ? rem_r - 56'(TWO_PI_Q32) : rem_r;
    r2 = (r1 >= 56'(TWO_PI_Q32)) ? r1 - 56'(TWO_PI_Q32) : r1;
    a0 = ang_t'({2'b00, r2[34:2]});
    if (a0 >= PI_Q30) a0 = a0 - TWO_PI_Q30;
    flip = 1'b0;
    a1 = a0;
    if (a0 > HALF_PI_Q30) begin
      a1 = a0 - PI_Q30;
      flip = 1'b1;
    end else if (a0 < -HALF_PI_Q30) begin
      a1 = a0 + PI_Q30;
      flip = 1'b1;
    end
  end

  ang_t ang_r;
  logic flip_r;
  amp_t amp11_r;
  always_ff @(posedge clk) begin
    ang_r   <= a1;
    flip_r  <= flip;
    amp11_r <= amp10_r;
  end

  cs_t c_w, s_w;
  amp_t amp12;
  ost_cordic #(.SW(AW)) u_cordic (
    .clk(clk), .in_ang(ang_r), .in_flip(flip_r), .in_side(amp11_r),
    .out_cos(c_w), .out_sin(s_w), .out_side(amp12)
  );

  // output: re = (a+p)c + (q-b)s ; im = (a-p)s + (b+q)c
  logic signed [24:0] sap_r, sqb_r, sam_r, sbq_r;
  cs_t c_r, s_r;
  always_ff @(posedge clk) begin
    sap_r <= 25'(amp12.a) + 25'(amp12.p);
    sqb_r <= 25'(amp12.q) - 25'(amp12.b);
    sam_r <= 25'(amp12.a) - 25'(amp12.p);
    sbq_r <= 25'(amp12.b) + 25'(amp12.q);
    c_r   <= c_w;
    s_r   <= s_w;
  end

  logic signed [59:0] m1_r, m2_r, m3_r, m4_r;
  always_ff @(posedge clk) begin
    m1_r <= 60'(sap_r) * 60'(c_r);
    m2_r <= 60'(sqb_r) * 60'(s_r);
    m3_r <= 60'(sam_r) * 60'(s_r);
    m4_r <= 60'(sbq_r) * 60'(c_r);
  end

  logic signed [60:0] acc_re, acc_im;
  logic signed [30:0] v_re, v_im;
  logic sat_re, sat_im;
  always_comb begin
    acc_re = 61'(m1_r) + 61'(m2_r) + (61'sd1 <<< 29);
    acc_im = 61'(m3_r) + 61'(m4_r) + (61'sd1 <<< 29);
    v_re   = 31'(acc_re >>> 30);
    v_im   = 31'(acc_im >>> 30);
    sat_re = (v_re > 31'sd8388607) || (v_re < -31'sd8388608);
    sat_im = (v_im > 31'sd8388607) || (v_im < -31'sd8388608);
  end

  always_ff @(posedge clk) begin
    out_height_re <= sat_re ? (v_re[30] ? -24'sd8388608 : 24'sd8388607) : v_re[23:0];
    out_height_im <= sat_im ? (v_im[30] ? -24'sd8388608 : 24'sd8388607) : v_im[23:0];
    out_saturated <= sat_re | sat_im;
  end
endmodule

@@ test/ocean_spectrum_time_update_test.sv @@
`timescale 1ns / 1ps
module ocean_spectrum_time_update_test;
  import ost_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [7:0]         in_row_index;
  logic [7:0]         in_col_index;
  logic signed [23:0] in_h0_re;
  logic signed [23:0] in_h0_im;
  logic signed [23:0] in_h0c_re;
  logic signed [23:0] in_h0c_im;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               out_valid;
  logic signed [23:0] out_height_re;
  logic signed [23:0] out_height_im;
  logic               out_saturated;

  ocean_spectrum_time_update dut (.*);

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               sat;
  } height_t;

  localparam int LATENCY   = 91;
  localparam int MAX_CYCLE = 400000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  height_t     height_q[$];
  logic [31:0] time_r;
  logic [15:0] kstep_r;
  logic [19:0] grav_r;
  int          errors;
  int          cycle;
  int          n_sent;
  int          n_checked;
  int          n_sat;
  int          idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("timeout at %0t", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip24(input longint acc, inout logic sat);
    longint v;
    v = (acc + (64'sd1 <<< 29)) >>> 30;
    if (v > 8388607) begin
      sat = 1'b1;
      return 8388607;
    end
    if (v < -8388608) begin
      sat = 1'b1;
      return -8388608;
    end
    return v;
  endfunction

  function automatic height_t predict_height(input logic [7:0] m, input logic [7:0] n,
                                             input longint a, input longint b,
                                             input longint p, input longint q);
    longint kx, ky, ang, x, y, nx, c, s;
    logic [63:0] kmag, omega, ph;
    logic flip;
    height_t h;
    kx = (longint'(n) - GRID_SIZE_DEF / 2) * longint'(kstep_r);
    ky = (longint'(m) - GRID_SIZE_DEF / 2) * longint'(kstep_r);
    kmag = isqrt(64'(kx * kx) + 64'(ky * ky));
    omega = isqrt(64'(grav_r) * kmag);
    ph = omega * 64'(time_r);
    ang = longint'((ph % 64'(TWO_PI_Q32)) >> 2);
    flip = 1'b0;
    if (ang >= longint'(PI_Q30)) ang = ang - longint'(TWO_PI_Q30);
    if (ang > longint'(HALF_PI_Q30)) begin
      ang = ang - longint'(PI_Q30);
      flip = 1'b1;
    end else if (ang < -longint'(HALF_PI_Q30)) begin
      ang = ang + longint'(PI_Q30);
      flip = 1'b1;
    end
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang = ang - longint'(atan_q30(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang = ang + longint'(atan_q30(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    h.sat = 1'b0;
    h.re = 24'(clip24(a * c - b * s + p * c + q * s, h.sat));
    h.im = 24'(clip24(a * s + b * c + q * c - p * s, h.sat));
    return h;
  endfunction

  always @(posedge clk) begin
    height_t e;
    if (rst_n && out_valid) begin
      if (height_q.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d", $time, out_height_re,
                 out_height_im);
        errors++;
      end else begin
        e = height_q.pop_front();
        n_checked++;
        if (e.sat) n_sat++;
        if (out_height_re !== e.re || out_height_im !== e.im ||
            out_saturated !== e.sat) begin
          $display("%0t: mismatch expected re=%0d im=%0d sat=%0b actual re=%0d im=%0d sat=%0b",
                   $time, e.re, e.im, e.sat, out_height_re, out_height_im,
                   out_saturated);
          errors++;
        end
      end
    end
  end

  task automatic send_bin(input logic [7:0] m, input logic [7:0] n,
                          input logic [23:0] a, input logic [23:0] b,
                          input logic [23:0] p, input logic [23:0] q);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_row_index <= m;
    in_col_index <= n;
    in_h0_re     <= a;
    in_h0_im     <= b;
    in_h0c_re    <= p;
    in_h0c_im    <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    height_q.push_back(predict_height(m, n, signed'(a), signed'(b), signed'(p),
                                      signed'(q)));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (height_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TIME:    time_r  = val;
      REG_KSTEP:   kstep_r = val[15:0];
      REG_GRAVITY: grav_r  = val[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_amp();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(2000)) - 24'd1000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    idle_pct = 0;
    send_bin(8'd128, 8'd128, 24'h010000, 24'h0, 24'h0, 24'h0);
    send_bin(8'd0, 8'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_bin(8'd255, 8'd255, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send_bin(8'd0, 8'd255, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    write_reg(REG_TIME, 32'h0001_8000);
    send_bin(8'd128, 8'd128, 24'h123456, 24'hEDCBA9, 24'h000001, 24'hFFFFFF);
    send_bin(8'd130, 8'd127, 24'h010000, 24'h020000, 24'hFF0000, 24'h008000);
    send_bin(8'd255, 8'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_bin(8'd0, 8'd0, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    write_reg(REG_TIME, 32'hFFFF_FFFF);
    write_reg(REG_KSTEP, 32'h0000_FFFF);
    write_reg(REG_GRAVITY, 32'h000F_FFFF);
    send_bin(8'd0, 8'd0, 24'h400000, 24'hC00000, 24'h3FFFFF, 24'h000000);
    send_bin(8'd255, 8'd128, 24'h7FFFFF, 24'h0, 24'h7FFFFF, 24'h0);
    send_bin(8'd129, 8'd1, 24'h0, 24'h800000, 24'h0, 24'h800000);
    write_reg(REG_KSTEP, 32'd0);
    send_bin(8'd37, 8'd201, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    write_reg(REG_GRAVITY, 32'd0);
    write_reg(REG_KSTEP, 32'd4118);
    send_bin(8'd10, 8'd250, 24'h050000, 24'hFB0000, 24'h001000, 24'h002000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_bin(8'd200, 8'd20, 24'h050000, 24'hFB0000, 24'h001000, 24'h002000);
    write_reg(REG_GRAVITY, 32'd642908);
    write_reg(REG_TIME, 32'd0);
  endtask

  task automatic test_random(input int pct, input int count);
    idle_pct = pct;
    write_reg(REG_TIME, $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom);
    write_reg(REG_KSTEP, $urandom_range(1) ? 32'($urandom_range(65535)) : 32'd4118);
    write_reg(REG_GRAVITY, 32'($urandom_range(1048575)));
    for (int i = 0; i < count; i++) begin
      send_bin(8'($urandom), 8'($urandom), rand_amp(), rand_amp(), rand_amp(),
               rand_amp());
      if ($urandom_range(15) == 0) idle_pct = 0;
      else if ($urandom_range(15) == 0) idle_pct = pct;
    end
  endtask

  initial begin
    errors = 0; cycle = 0; n_sent = 0; n_checked = 0; n_sat = 0; idle_pct = 0;
    time_r = TIME_RST; kstep_r = KSTEP_RST; grav_r = GRAVITY_RST;
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_row_index = '0; in_col_index = '0; in_h0_re = '0; in_h0_im = '0;
    in_h0c_re = '0; in_h0c_im = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    for (int ph = 0; ph < 4; ph++) begin
      test_random(0, 40);
      test_random(77, 40);
      test_random(35, 40);
      test_random(0, 30);
    end
    drain();
    $display("sent %0d bins over several time/k_step/gravity settings", n_sent);
    $display("checked %0d results, %0d saturated", n_checked, n_sat);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
